// ===== sv/rcfft_pkg.sv =====
// Shared types, constants and twiddle table for the radix-2 complex FFT.
// Used by rcfft_front, rcfft_back and radix2_complex_fft; no dependencies.
package rcfft_pkg;

    localparam int DATA_BITS         = 24;
    localparam int TABLE_LOG         = 6;
    localparam int POINTS_DEF        = 64;
    localparam int SAMPLE_BITS_DEF   = 18;
    localparam int TWIDDLE_BITS_DEF  = 18;
    localparam int QUEUE_DEPTH       = 4;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int CFG_DATA_BITS     = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LENGTH_LOG2 = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INVERSE     = 2'd1;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] re;
        logic signed [DATA_BITS-1:0] im;
    } cplx_t;

    typedef struct packed {
        logic  valid;
        cplx_t data;
    } qhead_t;

    // Saturate a wide signed value to the 24-bit data range
    function automatic logic signed [DATA_BITS-1:0] sat24(input logic signed [32:0] v);
        logic signed [32:0] hi_lim;
        logic signed [32:0] lo_lim;
        hi_lim = 33'sd8388607;
        lo_lim = -33'sd8388608;
        if (v > hi_lim)
            sat24 = 24'sh7fffff;
        else if (v < lo_lim)
            sat24 = 24'sh800000;
        else
            sat24 = v[DATA_BITS-1:0];
    endfunction

    // Quarter-wave cosine, Q1.31, rounded to nearest to tb bits
    function automatic logic [31:0] tw_mag(input logic [4:0] q, input int tb);
        logic [63:0] raw;
        int          sh;
        case (q)
            5'd0:    raw = 64'd2147483648;
            5'd1:    raw = 64'd2137142927;
            5'd2:    raw = 64'd2106220352;
            5'd3:    raw = 64'd2055013723;
            5'd4:    raw = 64'd1984016189;
            5'd5:    raw = 64'd1893911494;
            5'd6:    raw = 64'd1785567396;
            5'd7:    raw = 64'd1660027308;
            5'd8:    raw = 64'd1518500250;
            5'd9:    raw = 64'd1362349204;
            5'd10:   raw = 64'd1193077991;
            5'd11:   raw = 64'd1012316784;
            5'd12:   raw = 64'd821806413;
            5'd13:   raw = 64'd623381598;
            5'd14:   raw = 64'd418953276;
            5'd15:   raw = 64'd210490206;
            default: raw = 64'd0;
        endcase
        sh = 32 - tb;
        if (sh > 0)
            raw = (raw + (64'd1 << (sh - 1))) >> sh;
        tw_mag = raw[31:0];
    endfunction

endpackage

// ===== sv/rcfft_front.sv =====
// Front end of the FFT: accepts sample beats, saturates them to 24 bits
// and holds them in a short queue for the back end. Uses rcfft_pkg.
module rcfft_front #(
    parameter int SAMPLE_BITS = rcfft_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_real,
    input  logic signed [SAMPLE_BITS-1:0] sample_imag,
    output rcfft_pkg::qhead_t             head,
    input  logic                          pop
);

    localparam int PW = $clog2(rcfft_pkg::QUEUE_DEPTH);

    rcfft_pkg::cplx_t  qmem [rcfft_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       cnt_reg, cnt_next;
    logic              push;
    rcfft_pkg::cplx_t  sat_beat;

    // Clip incoming samples to the datapath range
    always_comb
    begin
        sat_beat.re = rcfft_pkg::sat24(33'(sample_real));
        sat_beat.im = rcfft_pkg::sat24(33'(sample_imag));
    end

    assign sample_ready = (cnt_reg != (PW+1)'(rcfft_pkg::QUEUE_DEPTH));
    assign push         = sample_valid && sample_ready;
    assign head.valid   = (cnt_reg != '0);
    assign head.data    = qmem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the beat
    always_ff @(posedge clk)
    begin
        if (push)
            qmem[wr_ptr_reg] <= sat_beat;
    end

`ifndef ASSERT_OFF
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW+1)'(rcfft_pkg::QUEUE_DEPTH))
        else $error("queue occupancy out of range");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count did not follow push");
`endif

endmodule

// ===== sv/rcfft_back.sv =====
// Back end of the FFT: loads queued samples in bit-reversed order into the
// work memory, runs the butterflies with one shared unit and emits bins.
// Uses rcfft_pkg.
module rcfft_back #(
    parameter int POINTS       = rcfft_pkg::POINTS_DEF,
    parameter int TWIDDLE_BITS = rcfft_pkg::TWIDDLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rcfft_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [rcfft_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  rcfft_pkg::qhead_t                     head,
    output logic                                  pop,
    output logic                                  bin_valid,
    input  logic                                  bin_ready,
    output logic signed [rcfft_pkg::DATA_BITS-1:0] bin_real,
    output logic signed [rcfft_pkg::DATA_BITS-1:0] bin_imag,
    output logic [5:0]                            bin_number,
    output logic                                  last_bin
);

    localparam int LOG_FLOOR = $clog2(POINTS + 1) - 1;
    localparam int AW        = (LOG_FLOOR > rcfft_pkg::TABLE_LOG) ?
                               rcfft_pkg::TABLE_LOG : LOG_FLOOR;
    localparam int DEPTH     = 1 << AW;
    localparam int TB        = TWIDDLE_BITS;
    localparam int PW        = TB + 25;
    localparam int FRAC      = TB - 1;
    localparam logic signed [PW:0] RND = (PW+1)'(1) << (FRAC - 1);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_WLO  = 3'd4;
    localparam logic [2:0] S_WHI  = 3'd5;
    localparam logic [2:0] S_ERD  = 3'd6;
    localparam logic [2:0] S_EOUT = 3'd7;

    logic [2:0]   state_reg, state_next;
    logic [2:0]   len_reg;
    logic         inv_reg;
    logic [AW:0]  load_cnt_reg, load_cnt_next;
    logic [2:0]   stage_reg, stage_next;
    logic [AW-1:0] bfly_reg, bfly_next;
    logic [AW-1:0] pos_reg, pos_next;

    rcfft_pkg::cplx_t mem [DEPTH];
    rcfft_pkg::cplx_t rda_reg, rdb_reg;
    logic signed [PW-1:0] p_cr_reg, p_si_reg, p_ci_reg, p_sr_reg;
    logic signed [26:0]   tr_reg, ti_reg;

    logic         out_valid_reg;
    logic signed [rcfft_pkg::DATA_BITS-1:0] out_re_reg, out_im_reg;
    logic [5:0]   out_num_reg;
    logic         out_last_reg;

    logic [2:0]   lg;
    logic [AW:0]  n_full;
    logic [AW-1:0] n_last, bfly_last;
    logic [AW:0]  hstage;
    logic [AW-1:0] off, lo, hi, ld_addr, rev;
    logic [5:0]   q6;
    logic [4:0]   q5, qc, qs;
    logic         c_neg;
    logic [31:0]  mc, ms;
    logic signed [TB:0] tw_c, tw_s, s_mag;
    logic         we;
    logic [AW-1:0] waddr, raddr_a;
    rcfft_pkg::cplx_t wdata;
    logic signed [PW:0] sum_r, sum_i, sh_r, sh_i;
    logic signed [27:0] lo_re, lo_im, hi_re, hi_im;
    logic signed [24:0] rnd_e, ext_re, ext_im, dv_re, dv_im;
    logic signed [rcfft_pkg::DATA_BITS-1:0] em_re, em_im;
    logic         out_load;

    assign cfg_ready = 1'b1;

    // Clamp length to between 1 and the built size
    always_comb
    begin
        if (len_reg == 3'd0)
            lg = 3'd1;
        else if (len_reg > 3'(AW))
            lg = 3'(AW);
        else
            lg = len_reg;
    end

    assign n_full    = (AW+1)'(1) << lg;
    assign n_last    = AW'(n_full - 1'b1);
    assign bfly_last = AW'((n_full >> 1) - 1'b1);

    // Butterfly addresses for the current stage and index
    assign hstage = (AW+1)'(1) << (stage_reg - 3'd1);
    assign off    = bfly_reg & AW'(hstage - 1'b1);
    assign lo     = AW'(((bfly_reg >> (stage_reg - 3'd1)) << stage_reg) | off);
    assign hi     = lo | AW'(hstage);

    // Bit-reversed load address
    always_comb
    begin
        for (int b = 0; b < AW; b++)
            rev[b] = load_cnt_reg[AW-1-b];
        ld_addr = rev >> (3'(AW) - lg);
    end

    // Twiddle from the quarter-wave table
    always_comb
    begin
        q6 = 6'(off) << (3'(rcfft_pkg::TABLE_LOG) - stage_reg);
        q5 = q6[4:0];
        if (q5 <= 5'd16)
        begin
            qc    = q5;
            qs    = 5'd16 - q5;
            c_neg = 1'b0;
        end
        else
        begin
            qc    = 5'(6'd32 - 6'(q5));
            qs    = q5 - 5'd16;
            c_neg = 1'b1;
        end
        mc    = rcfft_pkg::tw_mag(qc, TB);
        ms    = rcfft_pkg::tw_mag(qs, TB);
        tw_c  = c_neg ? -$signed({1'b0, mc[TB-1:0]}) : $signed({1'b0, mc[TB-1:0]});
        s_mag = $signed({1'b0, ms[TB-1:0]});
        tw_s  = inv_reg ? s_mag : -s_mag;
    end

    // Round the twiddle products and form the butterfly sum and difference
    always_comb
    begin
        sum_r = p_cr_reg - p_si_reg + RND;
        sum_i = p_ci_reg + p_sr_reg + RND;
        sh_r  = sum_r >>> FRAC;
        sh_i  = sum_i >>> FRAC;
        lo_re = rda_reg.re + tr_reg;
        lo_im = rda_reg.im + ti_reg;
        hi_re = rda_reg.re - tr_reg;
        hi_im = rda_reg.im - ti_reg;
    end

    // Scale for the inverse on the way out
    always_comb
    begin
        rnd_e  = 25'sd1 <<< (lg - 3'd1);
        ext_re = 25'(rda_reg.re);
        ext_im = 25'(rda_reg.im);
        dv_re  = (ext_re + rnd_e) >>> lg;
        dv_im  = (ext_im + rnd_e) >>> lg;
        em_re  = inv_reg ? dv_re[23:0] : rda_reg.re;
        em_im  = inv_reg ? dv_im[23:0] : rda_reg.im;
    end

    // Memory write port and read address selection
    always_comb
    begin
        we      = 1'b0;
        waddr   = ld_addr;
        wdata   = head.data;
        raddr_a = (state_reg == S_RD) ? lo : pos_reg;
        case (state_reg)
            S_LOAD:
            begin
                we = pop;
            end
            S_WLO:
            begin
                we       = 1'b1;
                waddr    = lo;
                wdata.re = rcfft_pkg::sat24(33'(lo_re));
                wdata.im = rcfft_pkg::sat24(33'(lo_im));
            end
            S_WHI:
            begin
                we       = 1'b1;
                waddr    = hi;
                wdata.re = rcfft_pkg::sat24(33'(hi_re));
                wdata.im = rcfft_pkg::sat24(33'(hi_im));
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    assign pop      = (state_reg == S_LOAD) && head.valid;
    assign out_load = (state_reg == S_EOUT) && (!out_valid_reg || bin_ready);

    // Sequence load, butterflies and emission
    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        stage_next    = stage_reg;
        bfly_next     = bfly_reg;
        pos_next      = pos_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (pop)
                begin
                    load_cnt_next = load_cnt_reg + 1'b1;
                    if (load_cnt_reg + 1'b1 == n_full)
                    begin
                        load_cnt_next = '0;
                        stage_next    = 3'd1;
                        bfly_next     = '0;
                        state_next    = S_RD;
                    end
                end
            end
            S_RD:    state_next = S_MUL;
            S_MUL:   state_next = S_ADD;
            S_ADD:   state_next = S_WLO;
            S_WLO:   state_next = S_WHI;
            S_WHI:
            begin
                state_next = S_RD;
                if (bfly_reg == bfly_last)
                begin
                    bfly_next = '0;
                    if (stage_reg == lg)
                    begin
                        pos_next   = '0;
                        state_next = S_ERD;
                    end
                    else
                        stage_next = stage_reg + 3'd1;
                end
                else
                    bfly_next = bfly_reg + 1'b1;
            end
            S_ERD:   state_next = S_EOUT;
            S_EOUT:
            begin
                if (out_load)
                begin
                    if (pos_reg == n_last)
                        state_next = S_LOAD;
                    else
                    begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = S_ERD;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
        // Restart the sample load count on a register write
        if (cfg_valid && (cfg_index == rcfft_pkg::CFG_LENGTH_LOG2 ||
                          cfg_index == rcfft_pkg::CFG_INVERSE))
            load_cnt_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            len_reg       <= 3'd6;
            inv_reg       <= 1'b0;
            load_cnt_reg  <= '0;
            stage_reg     <= 3'd1;
            bfly_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            stage_reg    <= stage_next;
            bfly_reg     <= bfly_next;
            pos_reg      <= pos_next;
            if (cfg_valid && cfg_index == rcfft_pkg::CFG_LENGTH_LOG2)
                len_reg <= cfg_data;
            if (cfg_valid && cfg_index == rcfft_pkg::CFG_INVERSE)
                inv_reg <= cfg_data[0];
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (bin_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Work memory: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (state_reg == S_RD || state_reg == S_ERD)
        begin
            rda_reg <= mem[raddr_a];
            rdb_reg <= mem[hi];
        end
    end

    // Butterfly datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            p_cr_reg <= tw_c * rdb_reg.re;
            p_si_reg <= tw_s * rdb_reg.im;
            p_ci_reg <= tw_c * rdb_reg.im;
            p_sr_reg <= tw_s * rdb_reg.re;
        end
        if (state_reg == S_ADD)
        begin
            tr_reg <= sh_r[26:0];
            ti_reg <= sh_i[26:0];
        end
        if (out_load)
        begin
            out_re_reg   <= rcfft_pkg::sat24(33'(em_re));
            out_im_reg   <= rcfft_pkg::sat24(33'(em_im));
            out_num_reg  <= 6'(pos_reg);
            out_last_reg <= (pos_reg == n_last);
        end
    end

    assign bin_valid  = out_valid_reg;
    assign bin_real   = out_re_reg;
    assign bin_imag   = out_im_reg;
    assign bin_number = out_num_reg;
    assign last_bin   = out_last_reg;

`ifndef ASSERT_OFF
    a_pop_only_load: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == S_LOAD)
        else $error("sample taken outside load");
    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOAD |-> load_cnt_reg < n_full)
        else $error("load count past block length");
    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD |-> (stage_reg >= 3'd1 && stage_reg <= lg))
        else $error("butterfly stage out of range");
    a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (last_bin == (bin_number == 6'(n_last))))
        else $error("last bin flag does not match bin number");
`endif

endmodule

// ===== sv/radix2_complex_fft.sv =====
// Top level of the radix-2 decimation-in-time complex FFT.
// Instantiates rcfft_front and rcfft_back; uses rcfft_pkg.
//
//   channel   direction  handshake                   payload
//   sample    in         sample_valid/sample_ready   sample_real, sample_imag
//   bin       out        bin_valid/bin_ready         bin_real, bin_imag, bin_number, last_bin
//   cfg       in         cfg_valid/cfg_ready         cfg_index, cfg_data
//
// The back end loads a block of N samples, then runs (N/2)*log2(N) butterflies on
// the single shared butterfly unit, each through read, multiply, add and two write
// states, then emits N bins, each through a memory read state and an output state.
// Samples keep flowing into a four-beat queue while the back end is busy, until it is full.
// Reset clears control state only; the work memory is not cleared.
// A stalled bin holds in the output register; cfg is always ready.
module radix2_complex_fft #(
    parameter int POINTS       = rcfft_pkg::POINTS_DEF,
    parameter int SAMPLE_BITS  = rcfft_pkg::SAMPLE_BITS_DEF,
    parameter int TWIDDLE_BITS = rcfft_pkg::TWIDDLE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rcfft_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [rcfft_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                   sample_valid,
    output logic                                   sample_ready,
    input  logic signed [SAMPLE_BITS-1:0]          sample_real,
    input  logic signed [SAMPLE_BITS-1:0]          sample_imag,
    output logic                                   bin_valid,
    input  logic                                   bin_ready,
    output logic signed [rcfft_pkg::DATA_BITS-1:0] bin_real,
    output logic signed [rcfft_pkg::DATA_BITS-1:0] bin_imag,
    output logic [5:0]                             bin_number,
    output logic                                   last_bin
);

    rcfft_pkg::qhead_t head;
    logic              pop;

    rcfft_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_real  (sample_real),
        .sample_imag  (sample_imag),
        .head         (head),
        .pop          (pop)
    );

    rcfft_back #(
        .POINTS       (POINTS),
        .TWIDDLE_BITS (TWIDDLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head       (head),
        .pop        (pop),
        .bin_valid  (bin_valid),
        .bin_ready  (bin_ready),
        .bin_real   (bin_real),
        .bin_imag   (bin_imag),
        .bin_number (bin_number),
        .last_bin   (last_bin)
    );

endmodule
